/* src/svcag_pkg.sv */
// ============================================================================
// svcag_pkg
// Shared types and constants for the strided view copy address generator:
// command, status and register codes, the dimension table entry and the
// control group that drives the table storage.
// ============================================================================
package svcag_pkg;

    // Default number of dimensions the tables hold.
    localparam int DEF_MAX_DIMS = 8;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_NEXT  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_CHUNK  = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;
    localparam logic [1:0] ST_OVF    = 2'd3;

    // Configuration register indexes.
    localparam int          CFG_IDX_W    = 3;
    localparam logic [2:0]  CFG_RANK     = 3'd0;
    localparam logic [2:0]  CFG_ELEM     = 3'd1;
    localparam logic [2:0]  CFG_BASE_OFF = 3'd2;
    localparam logic [2:0]  CFG_SRC_BASE = 3'd3;
    localparam logic [2:0]  CFG_DST_BASE = 3'd4;

    // One dimension descriptor. The rewind term is stride times extent,
    // modulo 2^32, worked out when the descriptor is loaded.
    typedef struct packed {
        logic [30:0] ext;
        logic [31:0] stride;
        logic [31:0] rewind;
    } t_dim_ent;

    // Write and clear controls for the table storage.
    typedef struct packed {
        logic dim_we;
        logic pos_we;
        logic pos_clr;
    } t_tbl_ctrl;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_RESP,
        S_NEXT,
        S_ODO,
        S_SCAN,
        S_MRG_CMP,
        S_MRG_CHK,
        S_CNT_MUL,
        S_CNT_CHK
    } t_state;

endpackage

/* src/strided_view_copy_address_gen.sv */
// ============================================================================
// strided_view_copy_address_gen
// Load and next: the command is captured on the transfer; the result is then
// registered from S_LOAD or S_NEXT once the output register is free. After a
// next, the odometer carry visits k dimensions (k >= 1 when any dimension is
// active), one table read per step. Start: a scan over the rank dimensions,
// then merge and count steps, cut short when a zero extent or an overflow ends
// it early; a stalled result holds the sequencer where it is. Reset is
// synchronous, active low, and clears control and transfer state; descriptors
// hold no value.
module strided_view_copy_address_gen
    import svcag_pkg::*;
#(
    parameter int   MAX_DIMS = DEF_MAX_DIMS,
    localparam int  DW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    localparam int  RW       = $clog2(MAX_DIMS + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [63:0]             i_cfg_data,
    // Command channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_command,
    input  logic [2:0]              i_dim_select,
    input  logic [30:0]             i_extent,
    input  logic signed [31:0]      i_stride_bytes,
    // Result channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [63:0]             o_src_addr,
    output logic [63:0]             o_dst_addr,
    output logic [30:0]             o_chunk_bytes,
    output logic                    o_last,
    output logic [1:0]              o_status
);

    // Configuration registers
    logic [3:0]     r_rank;
    logic [15:0]    r_elem;
    logic [30:0]    r_base_off;
    logic [63:0]    r_src_base;
    logic [63:0]    r_dst_base;

    // Transfer state
    logic [31:0]    r_cursor;
    logic [31:0]    r_done;
    logic [31:0]    r_total;
    logic [RW-1:0]  r_active;
    logic [30:0]    r_merged;
    logic [61:0]    r_dst_off;

    // Sequencer
    t_state         r_state;
    t_state         n_state;
    logic [DW-1:0]  r_dim;
    logic [DW-1:0]  n_dim;
    logic [RW-1:0]  r_rem;
    logic [30:0]    r_chunk;
    logic [30:0]    r_cnt;
    logic [61:0]    r_prod;
    logic [1:0]     r_status;

    // Held load command
    logic [2:0]     r_sel;
    logic [30:0]    r_ext;
    logic [31:0]    r_str;
    logic [31:0]    r_rew;

    // Output register
    logic           r_out_vld;
    logic [63:0]    r_out_src;
    logic [63:0]    r_out_dst;
    logic [30:0]    r_out_bytes;
    logic           r_out_last;
    logic [1:0]     r_out_status;

    // Combinational signals
    logic           in_fire;
    logic           out_free;
    logic           emit;
    logic           out_load;
    logic [63:0]    res_src;
    logic [63:0]    res_dst;
    logic [30:0]    res_bytes;
    logic           res_last;
    logic [1:0]     res_status;
    logic [RW-1:0]  eff_rank;
    logic [31:0]    in_rewind;
    logic           sel_ok;
    t_tbl_ctrl      tbl_ctrl;
    t_dim_ent       tbl_dim;
    t_dim_ent       tbl_wdata;
    logic [30:0]    tbl_pos;
    logic [30:0]    pos_new;
    logic [30:0]    pos_wdata;
    logic           wrap;
    logic           dim_is_top;
    logic           merge_hit;
    logic           prod_ovf;
    logic [30:0]    mul_a;
    logic [61:0]    mul_p;

    // Handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_vld || i_out_ready;
    assign out_load    = emit && out_free;

    // Rank saturated to the table depth.
    always_comb begin
        if (int'(r_rank) > MAX_DIMS) begin
            eff_rank = RW'(MAX_DIMS);
        end else begin
            eff_rank = RW'(r_rank);
        end
    end

    // Rewind term of an incoming descriptor, low 32 bits only.
    assign in_rewind = i_stride_bytes * {1'b0, i_extent};
    assign sel_ok    = (int'(r_sel) < MAX_DIMS);
    assign tbl_wdata = '{ext: r_ext, stride: r_str, rewind: r_rew};

    // Table storage
    svcag_tables #(
        .MAX_DIMS   (MAX_DIMS)
    ) u_tables (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (tbl_ctrl),
        .i_rd_addr   (n_dim),
        .i_dim_waddr (DW'(r_sel)),
        .i_dim_wdata (tbl_wdata),
        .i_pos_waddr (r_dim),
        .i_pos_wdata (pos_wdata),
        .o_dim       (tbl_dim),
        .o_pos       (tbl_pos)
    );

    // Odometer step on the dimension whose entry has just been read.
    assign pos_new   = tbl_pos + 31'd1;
    assign wrap      = (pos_new == tbl_dim.ext);
    assign pos_wdata = wrap ? '0 : pos_new;

    // Start sequencing helpers.
    assign dim_is_top = (RW'(r_dim) == (r_rem - RW'(1)));
    assign merge_hit  = !tbl_dim.stride[31] && (tbl_dim.stride[30:0] == r_chunk);
    assign mul_a      = (r_state == S_MRG_CMP) ? r_chunk : r_cnt;
    assign mul_p      = mul_a * tbl_dim.ext;
    assign prod_ovf   = |r_prod[61:31];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_command)
                        CMD_LOAD: n_state = S_LOAD;
                        CMD_START: begin
                            if (r_elem == '0) begin
                                n_state = S_RESP;
                            end else if (eff_rank == '0) begin
                                n_state = S_MRG_CMP;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_NEXT: n_state = (r_done < r_total) ? S_NEXT : S_RESP;
                        default:  n_state = S_RESP;
                    endcase
                end
            end
            S_LOAD, S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_NEXT: begin
                if (out_free) begin
                    n_state = (r_active == '0) ? S_IDLE : S_ODO;
                end
            end
            S_ODO: begin
                n_state = (wrap && r_dim != '0) ? S_ODO : S_IDLE;
            end
            S_SCAN: begin
                if (tbl_dim.ext == '0) begin
                    n_state = S_RESP;
                end else if (dim_is_top) begin
                    n_state = S_MRG_CMP;
                end
            end
            S_MRG_CMP: begin
                if (r_rem == '0) begin
                    n_state = S_RESP;
                end else if (merge_hit) begin
                    n_state = S_MRG_CHK;
                end else begin
                    n_state = S_CNT_MUL;
                end
            end
            S_MRG_CHK: n_state = prod_ovf ? S_RESP : S_MRG_CMP;
            S_CNT_MUL: n_state = S_CNT_CHK;
            S_CNT_CHK: n_state = (prod_ovf || dim_is_top) ? S_RESP : S_CNT_MUL;
            default:   n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: table controls, read address and result.
    always_comb begin
        emit             = 1'b0;
        tbl_ctrl         = '0;
        n_dim            = r_dim;
        res_src          = '0;
        res_dst          = '0;
        res_bytes        = '0;
        res_last         = 1'b0;
        res_status       = r_status;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_command == CMD_NEXT) begin
                        n_dim = DW'(r_active - RW'(1));
                    end else if (i_command == CMD_START) begin
                        n_dim          = '0;
                        tbl_ctrl.pos_clr = 1'b1;
                    end
                end
            end
            S_LOAD: begin
                emit            = 1'b1;
                tbl_ctrl.dim_we = sel_ok;
                res_status      = ST_ACCEPT;
            end
            S_RESP: begin
                emit = 1'b1;
            end
            S_NEXT: begin
                emit       = 1'b1;
                res_src    = r_src_base + {{32{r_cursor[31]}}, r_cursor};
                res_dst    = r_dst_base + {2'b00, r_dst_off};
                res_bytes  = r_merged;
                res_last   = ((r_done + 32'd1) == r_total);
                res_status = ST_CHUNK;
            end
            S_ODO: begin
                tbl_ctrl.pos_we = 1'b1;
                n_dim           = r_dim - DW'(1);
            end
            S_SCAN: begin
                if (!dim_is_top) begin
                    n_dim = r_dim + DW'(1);
                end
            end
            S_MRG_CMP: begin
                if (!merge_hit) begin
                    n_dim = '0;
                end
            end
            S_MRG_CHK: begin
                n_dim = DW'(r_rem - RW'(2));
            end
            S_CNT_CHK: begin
                n_dim = r_dim + DW'(1);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Registers: configuration, transfer state, sequencer data and results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank     <= '0;
            r_elem     <= 16'd1;
            r_base_off <= '0;
            r_src_base <= '0;
            r_dst_base <= '0;
            r_cursor   <= '0;
            r_done     <= '0;
            r_total    <= '0;
            r_active   <= '0;
            r_merged   <= '0;
            r_dst_off  <= '0;
            r_state    <= S_IDLE;
            r_dim      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dim   <= n_dim;

            // Configuration writes; indexes beyond the list are dropped.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RANK:     r_rank     <= i_cfg_data[3:0];
                    CFG_ELEM:     r_elem     <= i_cfg_data[15:0];
                    CFG_BASE_OFF: r_base_off <= i_cfg_data[30:0];
                    CFG_SRC_BASE: r_src_base <= i_cfg_data;
                    CFG_DST_BASE: r_dst_base <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // Output register.
            if (out_load) begin
                r_out_vld    <= 1'b1;
                r_out_src    <= res_src;
                r_out_dst    <= res_dst;
                r_out_bytes  <= res_bytes;
                r_out_last   <= res_last;
                r_out_status <= res_status;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                // Capture the command and clear the transfer on a start.
                S_IDLE: begin
                    if (in_fire) begin
                        r_sel <= i_dim_select;
                        r_ext <= i_extent;
                        r_str <= i_stride_bytes;
                        r_rew <= in_rewind;
                        r_status <= (i_command == CMD_START) ? ST_ACCEPT : ST_NONE;
                        if (i_command == CMD_START) begin
                            r_cursor  <= {1'b0, r_base_off};
                            r_done    <= '0;
                            r_total   <= '0;
                            r_active  <= '0;
                            r_merged  <= '0;
                            r_dst_off <= '0;
                            r_chunk   <= 31'(r_elem);
                            r_cnt     <= 31'd1;
                            r_rem     <= eff_rank;
                        end
                    end
                end
                // Trailing dimension merge.
                S_MRG_CMP: begin
                    if (r_rem == '0) begin
                        r_active <= '0;
                        r_merged <= r_chunk;
                        r_total  <= {1'b0, r_cnt};
                    end else if (merge_hit) begin
                        r_prod <= mul_p;
                    end
                end
                S_MRG_CHK: begin
                    if (prod_ovf) begin
                        r_status <= ST_OVF;
                    end else begin
                        r_chunk <= r_prod[30:0];
                        r_rem   <= r_rem - RW'(1);
                    end
                end
                // Chunk count over the remaining dimensions.
                S_CNT_MUL: begin
                    r_prod <= mul_p;
                end
                S_CNT_CHK: begin
                    if (prod_ovf) begin
                        r_status <= ST_OVF;
                    end else begin
                        r_cnt <= r_prod[30:0];
                        if (dim_is_top) begin
                            r_active <= r_rem;
                            r_merged <= r_chunk;
                            r_total  <= {1'b0, r_prod[30:0]};
                        end
                    end
                end
                // Chunk issued: advance the count and destination offset.
                S_NEXT: begin
                    if (out_free) begin
                        r_done    <= r_done + 32'd1;
                        r_dst_off <= r_dst_off + {31'd0, r_merged};
                    end
                end
                // Odometer step with carry into the next outer dimension.
                S_ODO: begin
                    if (wrap) begin
                        r_cursor <= r_cursor + tbl_dim.stride - tbl_dim.rewind;
                    end else begin
                        r_cursor <= r_cursor + tbl_dim.stride;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_src_addr    = r_out_src;
    assign o_dst_addr    = r_out_dst;
    assign o_chunk_bytes = r_out_bytes;
    assign o_last        = r_out_last;
    assign o_status      = r_out_status;

`ifndef NO_ASSERTIONS
    // The odometer only walks dimensions that the current transfer uses.
    a_odo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ODO) |-> (r_active != '0 && RW'(r_dim) < r_active))
        else $error("odometer outside the active dimensions");

    // Issued chunks never run past the chunk count.
    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done <= r_total)
        else $error("chunk count exceeded");

    // A delivered chunk always moves at least one byte.
    a_chunk_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_CHUNK) |-> (o_chunk_bytes != '0))
        else $error("empty chunk reported as valid");

    // Every chunk issued advances the chunk counter by exactly one.
    a_next_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NEXT && out_free) |=> (r_done == $past(r_done) + 32'd1))
        else $error("chunk counter did not advance");
`endif

endmodule

/* src/svcag_tables.sv */
// ============================================================================
// svcag_tables
// Dimension descriptor memory and position counter memory, each with one
// write port and one registered read port sharing a read address. The
// position counters carry a valid bit per entry so that an entry not yet
// written since the last start reads as zero.
// ============================================================================
module svcag_tables
    import svcag_pkg::*;
#(
    parameter int   MAX_DIMS = DEF_MAX_DIMS,
    localparam int  DW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_tbl_ctrl       i_ctrl,
    input  logic [DW-1:0]   i_rd_addr,
    input  logic [DW-1:0]   i_dim_waddr,
    input  t_dim_ent        i_dim_wdata,
    input  logic [DW-1:0]   i_pos_waddr,
    input  logic [30:0]     i_pos_wdata,
    output t_dim_ent        o_dim,
    output logic [30:0]     o_pos
);

    t_dim_ent               r_dim_mem [MAX_DIMS];
    logic [30:0]            r_pos_mem [MAX_DIMS];
    logic [MAX_DIMS-1:0]    r_pos_vld;
    t_dim_ent               r_dim_q;
    logic [30:0]            r_pos_q;
    logic                   r_vld_q;

    // Descriptor memory: written by load commands, with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.dim_we) begin
            r_dim_mem[i_dim_waddr] <= i_dim_wdata;
        end
        r_dim_q <= r_dim_mem[i_rd_addr];
    end

    // Position counter memory, written back by the odometer.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.pos_we) begin
            r_pos_mem[i_pos_waddr] <= i_pos_wdata;
        end
        r_pos_q <= r_pos_mem[i_rd_addr];
    end

    // Valid bits: cleared at reset and at every start, set on write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_vld <= '0;
            r_vld_q   <= 1'b0;
        end else begin
            if (i_ctrl.pos_clr) begin
                r_pos_vld <= '0;
            end else if (i_ctrl.pos_we) begin
                r_pos_vld[i_pos_waddr] <= 1'b1;
            end
            r_vld_q <= r_pos_vld[i_rd_addr];
        end
    end

    assign o_dim = r_dim_q;
    assign o_pos = r_vld_q ? r_pos_q : '0;

endmodule
